// File: rtl/core/matrix_row_column_mean_assert.svh
// Assertion macros for the matrix row and column mean block.
`ifndef MATRIX_ROW_COLUMN_MEAN_ASSERT_SVH
`define MATRIX_ROW_COLUMN_MEAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MRCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mrcm_pkg.sv
// Shared constants for the matrix row and column mean block.
`default_nettype none
package mrcm_pkg;

  // parameter defaults
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 16;

  // fixed field widths
  localparam int FRAC_W     = 8;
  localparam int MEAN_W     = 24;
  localparam int POS_W      = 6;
  localparam int NUM_ROWS_W = 7;
  localparam int NUM_COLS_W = 6;
  localparam int DIVISOR_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  // register reset values
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 7'd64;
  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 6'd32;

  // result kinds
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

endpackage
`default_nettype wire

// File: rtl/core/mrcm_colmem.sv
// Column sum memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module mrcm_colmem #(
  parameter int DEPTH  = mrcm_pkg::MAX_COLS_DEF,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 23
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     clr
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         valid;

  // valid bits: an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read with write-to-read bypass for the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mrcm_div.sv
// Radix-2 restoring divider: signed dividend by small positive count, truncating.
`default_nettype none
module mrcm_div #(
  parameter int DVD_W = 31
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [DVD_W-1:0]               dividend,
  input  logic [mrcm_pkg::DIVISOR_W-1:0]        divisor,
  output logic                                  done,
  output logic signed [mrcm_pkg::MEAN_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam int EXT_W = (DVD_W > mrcm_pkg::MEAN_W) ? DVD_W : mrcm_pkg::MEAN_W;
  localparam int DV_W  = mrcm_pkg::DIVISOR_W;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DVD_W-1:0]     q;
  logic [DV_W-1:0]      rem;
  logic [DV_W-1:0]      dvsr;
  logic                 neg;
  logic [DVD_W-1:0]     mag;
  logic [DV_W:0]        rem_sh;
  logic                 ge;
  logic [DV_W:0]        rem_sub;
  logic [EXT_W-1:0]     q_ext;
  logic [EXT_W-1:0]     q_res;

  // operand magnitude
  assign mag = dividend[DVD_W-1] ? DVD_W'(~dividend + 1'b1) : DVD_W'(dividend);

  // one quotient bit per cycle
  assign rem_sh  = {rem, q[DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvsr});
  assign rem_sub = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= mag;
      rem  <= '0;
      dvsr <= divisor;
      neg  <= dividend[DVD_W-1];
    end else if (busy) begin
      q   <= {q[DVD_W-2:0], ge};
      rem <= ge ? rem_sub[DV_W-1:0] : rem_sh[DV_W-1:0];
    end
  end

  // restore sign, keep the low result bits
  assign q_ext    = EXT_W'(q);
  assign q_res    = neg ? (~q_ext + 1'b1) : q_ext;
  assign quotient = q_res[mrcm_pkg::MEAN_W-1:0];

endmodule
`default_nettype wire

// File: rtl/core/matrix_row_column_mean.sv
// Top level: streaming matrix row and column averager.
//
//  channel | handshake          | word
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | element
//  out     | out_valid/out_stall| result_kind, position, mean_value, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Mid-row elements are taken one per cycle; column sums live in a memory with a
// registered read port, updated read-modify-write with a same-entry bypass.
// The row-ending element stalls input until the bit-serial divider (DIV_W = widest
// sum + 8, 31 at defaults) has formed the row average and the output is free.
// The matrix-ending row adds num_cols column averages, one divide each.
// Synchronous active-high reset; column sums read as zero via valid bits.
// Output is one register; the block waits while it is full and stalled.
`default_nettype none
module matrix_row_column_mean #(
  parameter int MAX_ROWS   = mrcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mrcm_pkg::MAX_COLS_DEF,
  parameter int DATA_WIDTH = mrcm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_WIDTH-1:0]          element,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  result_kind,
  output logic [mrcm_pkg::POS_W-1:0]            position,
  output logic signed [mrcm_pkg::MEAN_W-1:0]    mean_value,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mrcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mrcm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RS_W      = DATA_WIDTH + $clog2(MAX_COLS) + 1;
  localparam int CS_W      = DATA_WIDTH + $clog2(MAX_ROWS) + 1;
  localparam int SUM_W     = (RS_W > CS_W) ? RS_W : CS_W;
  localparam int DIV_W     = SUM_W + mrcm_pkg::FRAC_W;
  localparam int CNT_W     = mrcm_pkg::NUM_ROWS_W;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_ROW_DIV  = 3'd1;
  localparam logic [2:0] ST_COL_RD   = 3'd2;
  localparam logic [2:0] ST_COL_WAIT = 3'd3;
  localparam logic [2:0] ST_COL_DIV  = 3'd4;

  logic [2:0]                          state;
  logic [mrcm_pkg::NUM_ROWS_W-1:0]     num_rows;
  logic [mrcm_pkg::NUM_COLS_W-1:0]     num_cols;
  logic [mrcm_pkg::NUM_ROWS_W-1:0]     rows_eff;
  logic [mrcm_pkg::NUM_COLS_W-1:0]     cols_eff;
  logic [COL_IDX_W-1:0]                col_idx;
  logic [ROW_IDX_W-1:0]                row_idx;
  logic [ROW_IDX_W-1:0]                row_pos;
  logic [COL_IDX_W-1:0]                burst_col;
  logic                                mat_end;
  logic signed [RS_W-1:0]              row_total;
  logic signed [RS_W-1:0]              row_sum_new;
  logic                                accept;
  logic                                row_end;
  logic                                col_last;
  logic                                out_free;
  logic                                ld;
  logic                                s_vld;
  logic [COL_IDX_W-1:0]                s_addr;
  logic signed [DATA_WIDTH-1:0]        s_e;
  logic                                rd_en;
  logic [COL_IDX_W-1:0]                rd_addr;
  logic signed [CS_W-1:0]              rd_data;
  logic signed [CS_W-1:0]              wr_data;
  logic                                clr;
  logic                                div_start;
  logic signed [DIV_W-1:0]             div_dvd;
  logic [mrcm_pkg::DIVISOR_W-1:0]      div_dvsr;
  logic                                div_done;
  logic signed [mrcm_pkg::MEAN_W-1:0]  div_q;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= mrcm_pkg::NUM_ROWS_RST;
      num_cols <= mrcm_pkg::NUM_COLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrcm_pkg::CFG_NUM_ROWS: num_rows <= cfg_data;
        mrcm_pkg::CFG_NUM_COLS: num_cols <= cfg_data[mrcm_pkg::NUM_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // bounds clamped to 1..MAX
  always_comb begin
    if (num_rows == '0) begin
      rows_eff = mrcm_pkg::NUM_ROWS_W'(1);
    end else if (num_rows > mrcm_pkg::NUM_ROWS_W'(MAX_ROWS)) begin
      rows_eff = mrcm_pkg::NUM_ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = num_rows;
    end
    if (num_cols == '0) begin
      cols_eff = mrcm_pkg::NUM_COLS_W'(1);
    end else if (num_cols > mrcm_pkg::NUM_COLS_W'(MAX_COLS)) begin
      cols_eff = mrcm_pkg::NUM_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols;
    end
  end

  // input side
  assign in_stall    = (state != ST_RUN);
  assign accept      = in_valid && !in_stall;
  assign row_sum_new = row_total + RS_W'(element);
  assign row_end     = !((CNT_W'(col_idx) + CNT_W'(1)) < CNT_W'(cols_eff));
  assign col_last    = !((CNT_W'(burst_col) + CNT_W'(1)) < CNT_W'(cols_eff));

  // output register handshake
  assign out_free = !out_valid || !out_stall;
  assign ld       = ((state == ST_ROW_DIV) || (state == ST_COL_DIV)) && div_done && out_free;

  // column memory access: element updates, then the end-of-matrix sweep
  assign rd_en   = accept || (state == ST_COL_RD);
  assign rd_addr = accept ? col_idx : burst_col;
  assign wr_data = rd_data + CS_W'(s_e);
  assign clr     = ld && (state == ST_COL_DIV) && col_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_addr <= col_idx;
      s_e    <= element;
    end
  end

  mrcm_colmem #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_IDX_W),
    .DATA_W (CS_W)
  ) u_colmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s_vld),
    .wr_addr (s_addr),
    .wr_data (wr_data),
    .clr     (clr)
  );

  // divider launch: row sum at a row end, column sum in the sweep
  assign div_start = (accept && row_end) || (state == ST_COL_WAIT);

  always_comb begin
    if (state == ST_COL_WAIT) begin
      div_dvd  = {SUM_W'(rd_data), {mrcm_pkg::FRAC_W{1'b0}}};
      div_dvsr = rows_eff;
    end else begin
      div_dvd  = {SUM_W'(row_sum_new), {mrcm_pkg::FRAC_W{1'b0}}};
      div_dvsr = {1'b0, cols_eff};
    end
  end

  mrcm_div #(
    .DVD_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      col_idx   <= '0;
      row_idx   <= '0;
      row_total <= '0;
      mat_end   <= 1'b0;
      burst_col <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (accept) begin
            if (!row_end) begin
              col_idx   <= col_idx + 1'b1;
              row_total <= row_sum_new;
            end else begin
              col_idx   <= '0;
              row_total <= '0;
              state     <= ST_ROW_DIV;
              if ((CNT_W'(row_idx) + CNT_W'(1)) < rows_eff) begin
                row_idx <= row_idx + 1'b1;
                mat_end <= 1'b0;
              end else begin
                row_idx <= '0;
                mat_end <= 1'b1;
              end
            end
          end
        end
        ST_ROW_DIV: begin
          if (ld) begin
            burst_col <= '0;
            state     <= mat_end ? ST_COL_RD : ST_RUN;
          end
        end
        ST_COL_RD: begin
          state <= ST_COL_WAIT;
        end
        ST_COL_WAIT: begin
          state <= ST_COL_DIV;
        end
        ST_COL_DIV: begin
          if (ld) begin
            if (col_last) begin
              state <= ST_RUN;
            end else begin
              burst_col <= burst_col + 1'b1;
              state     <= ST_COL_RD;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // row number of the pending row average
  always_ff @(posedge clk) begin
    if (accept && row_end) begin
      row_pos <= row_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      mean_value <= div_q;
      if (state == ST_COL_DIV) begin
        result_kind <= mrcm_pkg::KIND_COL;
        position    <= mrcm_pkg::POS_W'(burst_col);
        last        <= col_last;
      end else begin
        result_kind <= mrcm_pkg::KIND_ROW;
        position    <= mrcm_pkg::POS_W'(row_pos);
        last        <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mrcm_checker.sv
// Port-level checks for the matrix row and column mean block, bound to the top.
`default_nettype none
`include "matrix_row_column_mean_assert.svh"
module mrcm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                result_kind,
  input logic [mrcm_pkg::POS_W-1:0]          position,
  input logic signed [mrcm_pkg::MEAN_W-1:0]  mean_value,
  input logic                                last
);

  // a stalled output word stays put
  `MRCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(position) && $stable(mean_value) && $stable(last), "output word changed while stalled")

  // only a column average closes a matrix
  `MRCM_ASSERT_IMPL(a_last_is_col, out_valid && last, result_kind == mrcm_pkg::KIND_COL, "last flag on a row average")

  // no element is taken until the column sweep has finished
  `MRCM_ASSERT_IMPL(a_sweep_blocks_in, out_valid && (result_kind == mrcm_pkg::KIND_COL) && !last, in_stall, "input open during column sweep")

endmodule

bind matrix_row_column_mean mrcm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .position    (position),
  .mean_value  (mean_value),
  .last        (last)
);
`default_nettype wire
